FILE: rtl/ssp_pkg.sv
// ---------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the single-source shortest path engine:
// beat structs, command and status codes, controller states and the
// control/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package ssp_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int VERT_BITS     = 6;
  localparam int VCNT_BITS     = 7;
  localparam int WEIGHT_BITS   = 16;
  localparam int DIST_BITS     = 32;
  localparam int MAX_EDGES_DEF = 256;

  localparam logic [VCNT_BITS-1:0] VCOUNT_RESET = VCNT_BITS'(MAX_VERTICES);

  localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_NEG = 2'd1;
  localparam logic [1:0] STAT_REJ = 2'd2;

  typedef struct packed {
    logic [1:0]                    command;
    logic [VERT_BITS-1:0]          edge_from;
    logic [VERT_BITS-1:0]          edge_to;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
    logic [VERT_BITS-1:0]          source_vertex;
  } ssp_in_t;

  typedef struct packed {
    logic [VERT_BITS-1:0]        vertex;
    logic signed [DIST_BITS-1:0] distance;
    logic                        reachable;
    logic                        has_predecessor;
    logic [VERT_BITS-1:0]        predecessor;
    logic [1:0]                  status;
    logic                        last;
  } ssp_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_ADD_RD,
    S_ADD_WR,
    S_RESP,
    S_RUN_INIT,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_EDGE_RD,
    S_RELAX,
    S_OUT_RD,
    S_OUT_LD
  } ssp_state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic head_rd;
    logic add_wr;
    logic resp_ld;
    logic run_init;
    logic edge_rd_head;
    logic edge_fetch;
    logic relax;
    logic next_u;
    logic out_rd;
    logic out_ld;
  } ssp_ctl_t;

  typedef struct packed {
    logic src_ok;
    logic head_empty;
    logic list_end;
    logic u_last;
    logic run_done;
    logic out_free;
  } ssp_sts_t;

endpackage

FILE: rtl/ssp_ctrl.sv
// ---------------------------------------------------------------------------
// ssp_ctrl
// Command sequencer: decodes accepted commands and steps the datapath
// through graph loads, relaxation passes, the cycle check and result output.
// ---------------------------------------------------------------------------
module ssp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  ssp_pkg::ssp_sts_t sts,
  output ssp_pkg::ssp_ctl_t ctl
);
  import ssp_pkg::*;

  ssp_state_t state_r;
  ssp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_CLEAR: state_nxt = S_CLEAR;
            CMD_ADD:   state_nxt = S_ADD_RD;
            CMD_RUN:   state_nxt = S_RUN_INIT;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR:    state_nxt = S_RESP;
      S_ADD_RD:   state_nxt = S_ADD_WR;
      S_ADD_WR:   state_nxt = S_RESP;
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_RUN_INIT: state_nxt = sts.src_ok ? S_HEAD_RD : S_OUT_RD;
      S_HEAD_RD:  state_nxt = S_HEAD_CHK;
      S_HEAD_CHK: begin
        if (sts.head_empty) begin
          state_nxt = sts.run_done ? S_OUT_RD : S_HEAD_RD;
        end else begin
          state_nxt = S_EDGE_RD;
        end
      end
      S_EDGE_RD:  state_nxt = S_RELAX;
      S_RELAX: begin
        if (sts.list_end) begin
          state_nxt = sts.run_done ? S_OUT_RD : S_HEAD_RD;
        end else begin
          state_nxt = S_EDGE_RD;
        end
      end
      S_OUT_RD:   state_nxt = S_OUT_LD;
      S_OUT_LD: begin
        if (sts.out_free) state_nxt = sts.u_last ? S_IDLE : S_OUT_RD;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      S_CLEAR:    ctl.clear = 1'b1;
      S_ADD_RD:   ctl.head_rd = 1'b1;
      S_ADD_WR:   ctl.add_wr = 1'b1;
      S_RESP:     ctl.resp_ld = sts.out_free;
      S_RUN_INIT: ctl.run_init = 1'b1;
      S_HEAD_RD:  ctl.head_rd = 1'b1;
      S_HEAD_CHK: begin
        ctl.next_u       = sts.head_empty;
        ctl.edge_rd_head = !sts.head_empty;
      end
      S_EDGE_RD:  ctl.edge_fetch = 1'b1;
      S_RELAX: begin
        ctl.relax  = 1'b1;
        ctl.next_u = sts.list_end;
      end
      S_OUT_RD:   ctl.out_rd = 1'b1;
      S_OUT_LD:   ctl.out_ld = sts.out_free;
      default:    ctl = '0;
    endcase
  end

  a_clear_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_CLEAR) |=> ##1 (state_r == S_RESP))
    else $error("clear did not reach response state");

  a_out_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.out_ld || ctl.resp_ld) |-> sts.out_free)
    else $error("result loaded while output register busy");

  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(ctl.relax || ctl.out_ld || ctl.add_wr))
    else $error("input ready during command work");

endmodule

FILE: rtl/ssp_dp.sv
// ---------------------------------------------------------------------------
// ssp_dp
// Datapath: vertex count register, adjacency lists (head table and edge
// store), distance/predecessor memories, reach flags, loop counters,
// relaxation arithmetic and the output register.
// ---------------------------------------------------------------------------
module ssp_dp #(
  parameter int MAX_EDGES = ssp_pkg::MAX_EDGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssp_pkg::ssp_in_t                    in_beat,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssp_pkg::VCNT_BITS-1:0]       cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ssp_pkg::ssp_out_t                   out_beat,
  input  ssp_pkg::ssp_ctl_t                   ctl,
  output ssp_pkg::ssp_sts_t                   sts
);
  import ssp_pkg::*;

  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EPW = EIW + 1;
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int EDW = VERT_BITS + WEIGHT_BITS + EPW;
  localparam logic [EPW-1:0] NO_EDGE = EPW'(MAX_EDGES);

  // configuration and command
  logic [VCNT_BITS-1:0] vcount_r;
  logic [VCNT_BITS-1:0] n_eff;
  logic [VERT_BITS-1:0] nm1;
  ssp_in_t              in_r;

  // graph storage
  logic [EIW-1:0]          head_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] head_vld_r;
  logic [EIW-1:0]          head_q_r;
  logic                    head_ok_r;
  logic [EDW-1:0]          edge_mem [MAX_EDGES];
  logic [EDW-1:0]          edge_q_r;
  logic [CW-1:0]           edge_total_r;
  logic                    reject;
  logic                    rej_r;

  // run state
  logic signed [DIST_BITS-1:0] dist_mem [MAX_VERTICES];
  logic [VERT_BITS-1:0]        pred_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]     reach_r;
  logic [MAX_VERTICES-1:0]     hp_r;
  logic signed [DIST_BITS-1:0] dist_a_q_r;
  logic signed [DIST_BITS-1:0] dist_b_q_r;
  logic [VERT_BITS-1:0]        pred_q_r;
  logic [VERT_BITS-1:0]        u_r;
  logic [VERT_BITS-1:0]        pass_r;
  logic                        check_r;
  logic                        neg_r;
  logic [VERT_BITS-1:0]        to_r;
  logic signed [WEIGHT_BITS-1:0] w_r;
  logic [EPW-1:0]              nxt_r;

  // output
  logic     out_valid_r;
  ssp_out_t out_r;

  logic [VERT_BITS-1:0]        head_addr;
  logic [EIW-1:0]              edge_addr;
  logic [VERT_BITS-1:0]        edge_q_to;
  logic signed [WEIGHT_BITS-1:0] edge_q_w;
  logic [EPW-1:0]              edge_q_next;
  logic signed [DIST_BITS:0]   sum_w;
  logic signed [DIST_BITS-1:0] sum_sat;
  logic                        v_ok;
  logic                        improve;
  logic                        src_ok;
  logic                        dist_we;
  logic [VERT_BITS-1:0]        dist_waddr;
  logic signed [DIST_BITS-1:0] dist_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else if (cfg_valid) begin
      vcount_r <= cfg_data;
    end
  end

  always_comb begin
    if (vcount_r == '0) begin
      n_eff = VCNT_BITS'(1);
    end else if (vcount_r > VCNT_BITS'(MAX_VERTICES)) begin
      n_eff = VCNT_BITS'(MAX_VERTICES);
    end else begin
      n_eff = vcount_r;
    end
  end
  assign nm1 = VERT_BITS'(n_eff - VCNT_BITS'(1));

  always_ff @(posedge clk) begin
    if (ctl.accept) in_r <= in_beat;
  end

  assign reject = (edge_total_r == CW'(MAX_EDGES))
               || ({1'b0, in_r.edge_from} >= n_eff)
               || ({1'b0, in_r.edge_to} >= n_eff);
  assign src_ok = {1'b0, in_r.source_vertex} < n_eff;

  // adjacency lists
  assign head_addr = (in_r.command == CMD_ADD) ? in_r.edge_from : u_r;

  always_ff @(posedge clk) begin
    if (ctl.head_rd) head_q_r <= head_mem[head_addr];
    if (ctl.add_wr && !reject) head_mem[in_r.edge_from] <= edge_total_r[EIW-1:0];
    if (ctl.add_wr) rej_r <= reject;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r   <= '0;
      head_ok_r    <= 1'b0;
      edge_total_r <= '0;
    end else begin
      if (ctl.head_rd) head_ok_r <= head_vld_r[head_addr];
      if (ctl.clear) begin
        head_vld_r   <= '0;
        edge_total_r <= '0;
      end else if (ctl.add_wr && !reject) begin
        head_vld_r[in_r.edge_from] <= 1'b1;
        edge_total_r               <= edge_total_r + CW'(1);
      end
    end
  end

  assign edge_q_to   = edge_q_r[EDW-1 -: VERT_BITS];
  assign edge_q_w    = edge_q_r[EPW +: WEIGHT_BITS];
  assign edge_q_next = edge_q_r[EPW-1:0];
  assign edge_addr   = ctl.edge_rd_head ? head_q_r : edge_q_next[EIW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.add_wr && !reject) begin
      edge_mem[edge_total_r[EIW-1:0]] <= {in_r.edge_to, in_r.edge_weight,
                                          head_ok_r ? {1'b0, head_q_r} : NO_EDGE};
    end
    if (ctl.edge_rd_head || ctl.edge_fetch) edge_q_r <= edge_mem[edge_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.edge_fetch) begin
      to_r  <= edge_q_to;
      w_r   <= edge_q_w;
      nxt_r <= edge_q_next;
    end
  end

  // relaxation
  assign sum_w = (DIST_BITS+1)'(dist_a_q_r) + (DIST_BITS+1)'(w_r);
  always_comb begin
    if (sum_w[DIST_BITS] != sum_w[DIST_BITS-1]) begin
      sum_sat = sum_w[DIST_BITS] ? DIST_MIN : DIST_MAX;
    end else begin
      sum_sat = sum_w[DIST_BITS-1:0];
    end
  end
  assign v_ok    = {1'b0, to_r} < n_eff;
  assign improve = reach_r[u_r] && v_ok && (!reach_r[to_r] || (sum_sat < dist_b_q_r));

  assign dist_we    = (ctl.run_init && src_ok) || (ctl.relax && improve && !check_r);
  assign dist_waddr = ctl.run_init ? in_r.source_vertex : to_r;
  assign dist_wdata = ctl.run_init ? '0 : sum_sat;

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    if (ctl.relax && improve && !check_r) pred_mem[to_r] <= u_r;
    if (ctl.edge_fetch || ctl.out_rd) dist_a_q_r <= dist_mem[u_r];
    if (ctl.edge_fetch) dist_b_q_r <= dist_mem[edge_q_to];
    if (ctl.out_rd) pred_q_r <= pred_mem[u_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r <= '0;
      hp_r    <= '0;
      u_r     <= '0;
      pass_r  <= '0;
      check_r <= 1'b0;
      neg_r   <= 1'b0;
    end else begin
      if (ctl.run_init) begin
        reach_r <= MAX_VERTICES'(src_ok) << in_r.source_vertex;
        hp_r    <= '0;
        u_r     <= '0;
        pass_r  <= '0;
        check_r <= (nm1 == '0);
        neg_r   <= 1'b0;
      end else begin
        if (ctl.relax && improve) begin
          if (check_r) begin
            neg_r <= 1'b1;
          end else begin
            reach_r[to_r] <= 1'b1;
            hp_r[to_r]    <= 1'b1;
          end
        end
        if (ctl.next_u) begin
          if (u_r == nm1) begin
            u_r <= '0;
            if (!check_r) begin
              pass_r <= pass_r + VERT_BITS'(1);
              if (pass_r + VERT_BITS'(1) == nm1) check_r <= 1'b1;
            end
          end else begin
            u_r <= u_r + VERT_BITS'(1);
          end
        end else if (ctl.out_ld) begin
          u_r <= u_r + VERT_BITS'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.resp_ld || ctl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.resp_ld) begin
      out_r.vertex          <= '0;
      out_r.distance        <= '0;
      out_r.reachable       <= 1'b0;
      out_r.has_predecessor <= 1'b0;
      out_r.predecessor     <= '0;
      out_r.status          <= (in_r.command == CMD_ADD && rej_r) ? STAT_REJ : STAT_OK;
      out_r.last            <= 1'b1;
    end else if (ctl.out_ld) begin
      out_r.vertex          <= u_r;
      out_r.distance        <= reach_r[u_r] ? dist_a_q_r : '0;
      out_r.reachable       <= reach_r[u_r];
      out_r.has_predecessor <= hp_r[u_r];
      out_r.predecessor     <= hp_r[u_r] ? pred_q_r : '0;
      out_r.status          <= neg_r ? STAT_NEG : STAT_OK;
      out_r.last            <= (u_r == nm1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  assign sts.src_ok     = src_ok;
  assign sts.head_empty = !head_ok_r;
  assign sts.list_end   = (nxt_r == NO_EDGE);
  assign sts.u_last     = (u_r == nm1);
  assign sts.run_done   = check_r && (u_r == nm1);
  assign sts.out_free   = !out_valid_r || out_ready;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= CW'(MAX_EDGES))
    else $error("edge count past store size");

  a_neg_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(neg_r) |-> $past(check_r))
    else $error("negative cycle flagged outside check pass");

  a_relax_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.relax && improve) |-> ({1'b0, to_r} < n_eff && reach_r[u_r]))
    else $error("relaxation of stale or unreached edge");

  a_check_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.relax && check_r) |=> $stable(reach_r))
    else $error("reach flags changed during check pass");

endmodule

FILE: rtl/single_source_shortest_paths.sv
// ---------------------------------------------------------------------------
// single_source_shortest_paths
// Bellman-Ford shortest path engine over a stored directed graph.
//
// in channel: one beat per command. clear empties the graph, add stores one
// edge (newest first within its tail vertex), run computes distances from
// source_vertex. cfg channel: vertex_count; the user must see that it is
// written only while idle, as the block itself does not enforce this.
// out channel: clear and add give one beat (status 2 on a rejected edge);
// run gives one beat per vertex in ascending order, last set on the final.
// A run makes n-1 relaxation passes plus the cycle check for n vertices,
// each edge visited through the edge store and the distance memory. One
// command is worked at a time; the next is accepted as soon as its last
// beat sits in the output register. Reset empties the graph and sets
// vertex_count to 64. A stalled receiver holds the output register and
// the run waits until the beat is taken.
// ---------------------------------------------------------------------------
module single_source_shortest_paths #(
  parameter int MAX_EDGES = ssp_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssp_pkg::ssp_in_t              in_beat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssp_pkg::ssp_out_t             out_beat,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssp_pkg::VCNT_BITS-1:0] cfg_data
);
  import ssp_pkg::*;

  ssp_ctl_t ctl;
  ssp_sts_t sts;

  ssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_beat.command),
    .sts      (sts),
    .ctl      (ctl)
  );

  ssp_dp #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
